>>> design/sha_pkg.sv
// ----------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and the rotate helper for the hash engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_OFFSET = 6'd63;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ROUND,
        S_ADD,
        S_EMIT
    } t_state;

    typedef logic [31:0] t_word;

    localparam t_word INIT_VALUE [8] = '{
        32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
        32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
    };

    localparam t_word ROUND_CONST [64] = '{
        32'h428A2F98, 32'h71374491, 32'hB5C0FBCF, 32'hE9B5DBA5,
        32'h3956C25B, 32'h59F111F1, 32'h923F82A4, 32'hAB1C5ED5,
        32'hD807AA98, 32'h12835B01, 32'h243185BE, 32'h550C7DC3,
        32'h72BE5D74, 32'h80DEB1FE, 32'h9BDC06A7, 32'hC19BF174,
        32'hE49B69C1, 32'hEFBE4786, 32'h0FC19DC6, 32'h240CA1CC,
        32'h2DE92C6F, 32'h4A7484AA, 32'h5CB0A9DC, 32'h76F988DA,
        32'h983E5152, 32'hA831C66D, 32'hB00327C8, 32'hBF597FC7,
        32'hC6E00BF3, 32'hD5A79147, 32'h06CA6351, 32'h14292967,
        32'h27B70A85, 32'h2E1B2138, 32'h4D2C6DFC, 32'h53380D13,
        32'h650A7354, 32'h766A0ABB, 32'h81C2C92E, 32'h92722C85,
        32'hA2BFE8A1, 32'hA81A664B, 32'hC24B8B70, 32'hC76C51A3,
        32'hD192E819, 32'hD6990624, 32'hF40E3585, 32'h106AA070,
        32'h19A4C116, 32'h1E376C08, 32'h2748774C, 32'h34B0BCB5,
        32'h391C0CB3, 32'h4ED8AA4A, 32'h5B9CCA4F, 32'h682E6FF3,
        32'h748F82EE, 32'h78A5636F, 32'h84C87814, 32'h8CC70208,
        32'h90BEFFFA, 32'hA4506CEB, 32'hBEF9A3F7, 32'hC67178F2
    };

    // Control from the sequencer to the round unit.
    typedef struct packed {
        logic       init;   // copy chaining words into working variables
        logic       step;   // one compression round
        logic       add;    // fold working variables into chaining words
        logic       reset_h; // return chaining words to the initial value
        logic [5:0] rnd;
    } t_rnd_ctrl;

    function automatic t_word rotr(input t_word x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

>>> design/sha_round.sv
// ----------------------------------------------------------------------------
// SHA-256 round unit
// One shared compression round plus message schedule, reused 64 times.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_round (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire sha_pkg::t_rnd_ctrl i_ctrl,
    input  wire logic [31:0]       i_w_load,
    output logic [31:0]            o_h [8]
);
    import sha_pkg::*;

    t_word r_h [8];
    t_word r_v [8];
    t_word r_w [16];

    t_word w_cur, w_new, s0, s1, t1, t2, e, a;

    always_comb begin
        s0 = rotr(r_w[1], 7) ^ rotr(r_w[1], 18) ^ (r_w[1] >> 3);
        s1 = rotr(r_w[14], 17) ^ rotr(r_w[14], 19) ^ (r_w[14] >> 10);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        // rounds 0..15 use the loaded words as they stand
        w_cur = (i_ctrl.rnd < 6'd16) ? r_w[0] : w_new;
        e = r_v[4];
        a = r_v[0];
        t1 = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
           + ((e & r_v[5]) ^ (~e & r_v[6])) + ROUND_CONST[i_ctrl.rnd] + w_cur;
        t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
           + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.reset_h) begin
            for (int i = 0; i < 8; i++) r_h[i] <= INIT_VALUE[i];
        end else if (i_ctrl.add) begin
            for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
        end
    end

    // The window shifts in loaded words during load, and in each round.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.init) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end else if (i_ctrl.step) begin
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (i_ctrl.init || i_ctrl.step) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i + 1];
            r_w[15] <= i_ctrl.init ? i_w_load : w_cur;
        end
    end

    assign o_h = r_h;
endmodule
`default_nettype wire

>>> design/sha256_hash_engine_core.sv
// ----------------------------------------------------------------------------
// SHA-256 hash engine core
// Byte-serial SHA-256 with an iterative single-round compression unit.
// ----------------------------------------------------------------------------
// A data byte is absorbed in idle; the 64th byte of a block starts 16
// word loads, 64 rounds and one add. Finish runs one or two such
// compressions, then eight digest transfers, one per cycle while ready.
// No byte is taken while the single shared round unit works on a block.
// Reset (synchronous, active low) loads the initial value and clears count.
`default_nettype none
module sha256_hash_engine_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,  // data_byte
    input  wire logic        s_axis_tuser,  // command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [39:0]      m_axis_tdata,  // digest_word[31:0], word_index[34:32]
    output logic             m_axis_tlast   // last_word
);
    import sha_pkg::*;

    // Block buffer: sixteen big-endian words, written one byte per transfer and
    // read as one registered word per cycle during the load.
    logic [31:0] r_buf [16];
    logic [31:0] r_word;     // buffer word for the current load cycle

    t_state      r_state, n_state;
    logic [60:0] r_total;
    logic [5:0]  r_cnt;      // load word index, round index
    logic [2:0]  r_idx;      // digest word index
    logic        r_fin;      // inside a finish sequence
    logic        r_second;   // finish needs a second padded block
    logic        r_pad_blk;  // current finish block is the second padded block
    logic [5:0]  r_off;      // byte offset latched at finish
    logic [63:0] r_bits;
    t_rnd_ctrl   ctrl;
    logic [31:0] w_load;
    t_word       h [8];

    wire acc = s_axis_tvalid && s_axis_tready;
    wire [5:0] off = r_total[5:0];
    // The read runs a word ahead of the load, so word 0 is fetched while
    // the sequencer is still idle or adding.
    wire [3:0] rd_addr = (r_state == S_LOAD) ? r_cnt[3:0] + 4'd1 : 4'd0;

    // Padded view of a byte during finish.
    function automatic logic [7:0] pad_byte(input logic [5:0] p, input logic [7:0] b,
                                             input logic [5:0] o, input logic blk2,
                                             input logic two, input logic [63:0] bits);
        logic [7:0] v;
        v = 8'h00;
        if (!blk2 && p < o) v = b;
        else if (!blk2 && p == o) v = PAD_BYTE;
        if ((blk2 || !two) && p >= LEN_OFFSET)
            v = bits[8 * (7 - (p - LEN_OFFSET)) +: 8];
        return v;
    endfunction

    always_comb begin
        logic [5:0] p;
        w_load = '0;
        for (int k = 0; k < 4; k++) begin
            p = {r_cnt[3:0], 2'(k)};
            w_load[8 * (3 - k) +: 8] = r_fin ?
                pad_byte(p, r_word[8 * (3 - k) +: 8], r_off, r_pad_blk, r_second, r_bits)
                : r_word[8 * (3 - k) +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc && s_axis_tuser == CMD_ABSORB)
            r_buf[off[5:2]][8 * (3 - int'(off[1:0])) +: 8] <= s_axis_tdata;
        r_word <= r_buf[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        ctrl = '0;
        ctrl.rnd = r_cnt;
        s_axis_tready = 1'b0;
        m_axis_tvalid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (acc && (s_axis_tuser == CMD_FINISH || off == LAST_OFFSET))
                    n_state = S_LOAD;
            end
            S_LOAD: begin
                ctrl.init = 1'b1;
                if (r_cnt == 6'd15) n_state = S_ROUND;
            end
            S_ROUND: begin
                ctrl.step = 1'b1;
                if (r_cnt == LAST_OFFSET) n_state = S_ADD;
            end
            S_ADD: begin
                ctrl.add = 1'b1;
                if (!r_fin) n_state = S_IDLE;
                else if (r_second && !r_pad_blk) n_state = S_LOAD;
                else n_state = S_EMIT;
            end
            S_EMIT: begin
                m_axis_tvalid = 1'b1;
                if (m_axis_tready && r_idx == 3'd7) begin
                    ctrl.reset_h = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0; r_cnt <= '0; r_idx <= '0;
            r_fin <= 1'b0; r_second <= 1'b0; r_pad_blk <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0; r_idx <= '0; r_pad_blk <= 1'b0;
                    if (acc && s_axis_tuser == CMD_ABSORB) begin
                        r_total <= r_total + 61'd1;
                        r_fin <= 1'b0;
                    end else if (acc) begin
                        r_fin <= 1'b1;
                        r_second <= (off >= 6'd56);
                        r_off <= off;
                        r_bits <= {r_total, 3'b000};
                    end
                end
                S_LOAD:  r_cnt <= (r_cnt == 6'd15) ? 6'd0 : r_cnt + 6'd1;
                S_ROUND: r_cnt <= r_cnt + 6'd1;
                S_ADD: begin
                    r_cnt <= '0;
                    if (r_fin) r_pad_blk <= 1'b1;
                end
                S_EMIT: if (m_axis_tready) begin
                    r_idx <= r_idx + 3'd1;
                    if (r_idx == 3'd7) begin
                        r_total <= '0; r_fin <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    sha_round u_round (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (ctrl),
        .i_w_load (w_load),
        .o_h      (h)
    );

    assign m_axis_tdata = {5'b0, r_idx, h[r_idx]};
    assign m_axis_tlast = (r_idx == 3'd7);

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid) else $error("ready while emitting");
    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("no return to idle after digest");
    a_round_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD && r_cnt == 6'd15) |=> r_state == S_ROUND)
        else $error("load did not hand over to rounds");
endmodule
`default_nettype wire
